// ----- rtl/core/crp_pkg.sv -----
// Shared types, codes and defaults for the table seating sampler.
package crp_pkg;

    localparam int NUM_TYPES_DEF  = 1024;
    localparam int MAX_TABLES_DEF = 16;
    localparam int COUNT_BITS_DEF = 16;

    localparam int TOT_CUST_W = 26;
    localparam int TOT_TAB_W  = 15;
    localparam int PADDR_W    = 4;

    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam logic [1:0] CHG_NONE   = 2'd0;
    localparam logic [1:0] CHG_GLOBAL = 2'd1;
    localparam logic [1:0] CHG_LOCAL  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_OVF   = 2'd3;

    localparam logic [1:0] REG_LAMBDA = 2'd0;
    localparam logic [1:0] REG_DISC   = 2'd1;
    localparam logic [1:0] REG_THETA  = 2'd2;

    typedef struct packed {
        logic        opcode;
        logic [9:0]  word_type;
        logic [15:0] global_prob;
        logic [15:0] local_prob;
        logic [15:0] random_draw;
    } t_in_beat;

    typedef struct packed {
        logic [1:0] change;
        logic [1:0] status;
    } t_out_beat;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_QUOT,
        S_REM,
        S_SECRD,
        S_SEC,
        S_PREP,
        S_WEIGHT,
        S_WINIT,
        S_SUM,
        S_TGT_LO,
        S_TGT_HI,
        S_PICK,
        S_APPLY,
        S_SHIFT,
        S_FINISH,
        S_RESULT
    } t_state;

endpackage

// ----- rtl/core/crp_table_seating_sampler.sv -----
// Top level: restaurant seating sampler with section and table memories.
//
//  channel   direction  handshake                  payload
//  in        input      i_in_valid / o_in_stall    t_in_beat  (i_in_data)
//  out       output     o_out_valid / i_out_stall  t_out_beat (o_out_data)
//  cfg       input      APB psel/penable/pwrite    32-bit registers
//
// One item at a time; the table memory's single read port is swept once to total the weights
// and once to pick, and an erase sweeps the tables after the picked one to close the gap.
// After reset the section memory is cleared, one entry a cycle, with the input stalled; a held
// result stalls the next.
module crp_table_seating_sampler
    import crp_pkg::*;
#(
    parameter int NUM_TYPES  = NUM_TYPES_DEF,
    parameter int MAX_TABLES = MAX_TABLES_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  t_in_beat           i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_out_beat          o_out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int CB      = COUNT_BITS;
    localparam int SEC_W   = $clog2(NUM_TYPES);
    localparam int TI_W    = (MAX_TABLES > 1) ? $clog2(MAX_TABLES) : 1;
    localparam int NT_W    = $clog2(MAX_TABLES + 1);
    localparam int TAB_AW  = SEC_W + TI_W;
    localparam int TAB_DW  = CB + 1;
    localparam int SEC_DW  = CB + NT_W;
    localparam int WT_W    = (CB + 16 > 32) ? CB + 16 : 32;
    localparam int TOT_W   = WT_W + NT_W + 1;
    localparam int HI_W    = TOT_W - 32;
    localparam int RECIP_K = 27;
    localparam logic [27:0] RECIP =
        28'(((64'd1 << RECIP_K) + 64'(NUM_TYPES) - 64'd1) / 64'(NUM_TYPES));
    localparam logic [NT_W-1:0] N_MAX = NT_W'(MAX_TABLES);
    localparam logic [SEC_W-1:0] SEC_LAST = SEC_W'(NUM_TYPES - 1);

    // configuration
    logic [15:0] r_lambda;
    logic [15:0] r_disc;
    logic [23:0] r_theta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lambda <= 16'd32768;
            r_disc   <= 16'd32768;
            r_theta  <= 24'd65536;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_LAMBDA: r_lambda <= pwdata[15:0];
                REG_DISC:   r_disc   <= pwdata[15:0];
                REG_THETA:  r_theta  <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_LAMBDA: prdata = {16'd0, r_lambda};
            REG_DISC:   prdata = {16'd0, r_disc};
            REG_THETA:  prdata = {8'd0, r_theta};
            default:    prdata = 32'd0;
        endcase
    end

    assign pready = 1'b1;

    // memories
    logic              tab_we;
    logic [TAB_AW-1:0] tab_waddr;
    logic [TAB_DW-1:0] tab_wdata;
    logic [TAB_AW-1:0] tab_raddr;
    logic [TAB_DW-1:0] tab_rdata;
    logic              sec_we;
    logic [SEC_W-1:0]  sec_waddr;
    logic [SEC_DW-1:0] sec_wdata;
    logic [SEC_DW-1:0] sec_rdata;

    // sequencer state
    t_state            r_state, n_state;
    t_in_beat          r_item, n_item;
    logic [9:0]        r_q, n_q;
    logic [SEC_W-1:0]  r_sec, n_sec;
    logic [SEC_W-1:0]  r_clr, n_clr;
    logic [CB-1:0]     r_cust, n_cust;
    logic [NT_W-1:0]   r_n, n_n;
    logic [15:0]       r_gb, n_gb;
    logic [15:0]       r_lb, n_lb;
    logic [31:0]       r_common, n_common;
    logic [31:0]       r_wg, n_wg;
    logic [31:0]       r_wl, n_wl;
    logic [TOT_W-1:0]  r_total, n_total;
    logic [47:0]       r_plo, n_plo;
    logic [TOT_W-1:0]  r_target, n_target;
    logic [TOT_W-1:0]  r_run, n_run;
    logic [NT_W-1:0]   r_idx, n_idx;
    logic [NT_W-1:0]   r_didx, n_didx;
    logic              r_dv, n_dv;
    logic [NT_W-1:0]   r_pick, n_pick;
    logic [TAB_DW-1:0] r_ent, n_ent;
    logic              r_new, n_new;
    logic              r_glob, n_glob;
    logic [1:0]        r_change, n_change;
    t_out_beat         r_res, n_res;
    logic [TOT_TAB_W-1:0]  r_tot_tab, n_tot_tab;
    logic [TOT_CUST_W-1:0] r_tot_cust, n_tot_cust;
    logic              r_out_valid, n_out_valid;
    t_out_beat         r_out, n_out;

    // datapath temporaries
    logic [37:0]       prod_q;
    logic [26:0]       prod_r;
    logic [NT_W-1:0]   sec_n;
    logic [32:0]       prod_dec;
    logic [16:0]       gl_sum;
    logic [47:0]       prod_wg;
    logic [47:0]       prod_wl;
    logic [WT_W-1:0]   w_cur;
    logic [TOT_W-1:0]  run_nx;
    logic [HI_W+15:0]  prod_hi;
    logic [TOT_W+15:0] prod_all;
    logic              scan_issue;
    logic [CB-1:0]     cnt_adj;
    logic [NT_W-1:0]   shift_dst;

    crp_ram #(
        .DEPTH  (1 << TAB_AW),
        .W_DATA (TAB_DW)
    ) u_tab_ram (
        .i_clk   (i_clk),
        .i_we    (tab_we),
        .i_waddr (tab_waddr),
        .i_wdata (tab_wdata),
        .i_raddr (tab_raddr),
        .o_rdata (tab_rdata)
    );

    crp_ram #(
        .DEPTH  (NUM_TYPES),
        .W_DATA (SEC_DW)
    ) u_sec_ram (
        .i_clk   (i_clk),
        .i_we    (sec_we),
        .i_waddr (sec_waddr),
        .i_wdata (sec_wdata),
        .i_raddr (r_sec),
        .o_rdata (sec_rdata)
    );

    assign tab_raddr  = {r_sec, r_idx[TI_W-1:0]};
    assign scan_issue = (r_idx < r_n);
    assign o_in_stall = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_dv        <= 1'b0;
            r_tot_tab   <= '0;
            r_tot_cust  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_dv        <= n_dv;
            r_tot_tab   <= n_tot_tab;
            r_tot_cust  <= n_tot_cust;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item   <= n_item;
        r_q      <= n_q;
        r_sec    <= n_sec;
        r_cust   <= n_cust;
        r_n      <= n_n;
        r_gb     <= n_gb;
        r_lb     <= n_lb;
        r_common <= n_common;
        r_wg     <= n_wg;
        r_wl     <= n_wl;
        r_total  <= n_total;
        r_plo    <= n_plo;
        r_target <= n_target;
        r_run    <= n_run;
        r_idx    <= n_idx;
        r_didx   <= n_didx;
        r_pick   <= n_pick;
        r_ent    <= n_ent;
        r_new    <= n_new;
        r_glob   <= n_glob;
        r_change <= n_change;
        r_res    <= n_res;
        r_out    <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_q         = r_q;
        n_sec       = r_sec;
        n_clr       = r_clr;
        n_cust      = r_cust;
        n_n         = r_n;
        n_gb        = r_gb;
        n_lb        = r_lb;
        n_common    = r_common;
        n_wg        = r_wg;
        n_wl        = r_wl;
        n_total     = r_total;
        n_plo       = r_plo;
        n_target    = r_target;
        n_run       = r_run;
        n_idx       = r_idx;
        n_didx      = r_didx;
        n_dv        = 1'b0;
        n_pick      = r_pick;
        n_ent       = r_ent;
        n_new       = r_new;
        n_glob      = r_glob;
        n_change    = r_change;
        n_res       = r_res;
        n_tot_tab   = r_tot_tab;
        n_tot_cust  = r_tot_cust;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;

        tab_we    = 1'b0;
        tab_waddr = {r_sec, r_pick[TI_W-1:0]};
        tab_wdata = '0;
        sec_we    = 1'b0;
        sec_waddr = r_sec;
        sec_wdata = '0;

        prod_q   = 38'(r_item.word_type) * 38'(RECIP);
        prod_r   = 27'(r_q) * 27'(NUM_TYPES);
        sec_n    = (sec_rdata[NT_W-1:0] > N_MAX) ? N_MAX : sec_rdata[NT_W-1:0];
        gl_sum   = 17'(r_gb) + 17'(r_lb);
        prod_dec = 33'(r_item.random_draw) * 33'(gl_sum);
        prod_wg  = 48'(r_common) * 48'(r_gb);
        prod_wl  = 48'(r_common) * 48'(r_lb);
        if (r_item.opcode == OP_ADD) begin
            w_cur = WT_W'({tab_rdata[CB-1:0], 16'h0000}) - WT_W'(r_disc);
        end else begin
            w_cur = WT_W'(tab_rdata[CB-1:0]);
        end
        run_nx    = r_run + TOT_W'(w_cur);
        prod_hi   = (HI_W + 16)'(r_total[TOT_W-1:32]) * (HI_W + 16)'(r_item.random_draw);
        prod_all  = (TOT_W + 16)'(r_plo) + ((TOT_W + 16)'(prod_hi) << 32);
        cnt_adj   = (r_item.opcode == OP_ADD) ? r_ent[CB-1:0] + 1'b1 : r_ent[CB-1:0] - 1'b1;
        shift_dst = r_didx - 1'b1;

        case (r_state)
            S_CLEAR: begin
                sec_we    = 1'b1;
                sec_waddr = r_clr;
                sec_wdata = '0;
                n_clr     = r_clr + 1'b1;
                if (r_clr == SEC_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item  = i_in_data;
                    n_state = S_QUOT;
                end
            end
            S_QUOT: begin
                n_q     = prod_q[RECIP_K +: 10];
                n_state = S_REM;
            end
            S_REM: begin
                n_sec   = SEC_W'(27'(r_item.word_type) - prod_r);
                n_state = S_SECRD;
            end
            S_SECRD: begin
                n_state = S_SEC;
            end
            S_SEC: begin
                n_cust  = sec_rdata[SEC_DW-1:NT_W];
                n_n     = sec_n;
                n_gb    = 16'((33'(r_item.global_prob) * (33'd65536 - 33'(r_lambda))) >> 16);
                n_lb    = 16'((32'(r_item.local_prob) * 32'(r_lambda)) >> 16);
                n_state = S_PREP;
            end
            S_PREP: begin
                n_change = CHG_NONE;
                n_total  = '0;
                n_run    = '0;
                n_idx    = '0;
                if (r_item.opcode == OP_ADD) begin
                    if (r_cust == '1 || r_tot_cust == '1) begin
                        n_res   = '{change: CHG_NONE, status: ST_OVF};
                        n_state = S_RESULT;
                    end else if (r_cust == '0 || r_n == '0) begin
                        n_new   = 1'b1;
                        n_glob  = (gl_sum == '0) || (prod_dec < {1'b0, r_gb, 16'h0000});
                        n_state = S_APPLY;
                    end else begin
                        n_common = 32'(r_theta) + 32'(r_disc) * 32'(r_tot_tab);
                        n_state  = S_WEIGHT;
                    end
                end else begin
                    if (r_cust == '0 || r_n == '0) begin
                        n_res   = '{change: CHG_NONE, status: ST_EMPTY};
                        n_state = S_RESULT;
                    end else begin
                        n_state = S_SUM;
                    end
                end
            end
            S_WEIGHT: begin
                n_wg    = prod_wg[47:16];
                n_wl    = prod_wl[47:16];
                n_state = S_WINIT;
            end
            S_WINIT: begin
                n_total = TOT_W'(r_wg) + TOT_W'(r_wl);
                n_state = S_SUM;
            end
            S_SUM: begin
                if (r_dv) begin
                    n_total = r_total + TOT_W'(w_cur);
                end
                if (scan_issue) begin
                    n_idx = r_idx + 1'b1;
                    n_dv  = 1'b1;
                end else if (!r_dv) begin
                    n_state = S_TGT_LO;
                end
            end
            S_TGT_LO: begin
                n_plo   = 48'(r_total[31:0]) * 48'(r_item.random_draw);
                n_state = S_TGT_HI;
            end
            S_TGT_HI: begin
                n_target = prod_all[TOT_W+15:16];
                n_idx    = '0;
                n_run    = '0;
                n_state  = S_PICK;
            end
            S_PICK: begin
                if (r_dv) begin
                    n_run  = run_nx;
                    n_ent  = tab_rdata;
                    n_pick = r_didx;
                end
                if (r_dv && run_nx > r_target) begin
                    n_new   = 1'b0;
                    n_state = S_APPLY;
                end else if (r_dv || scan_issue) begin
                    if (scan_issue) begin
                        n_idx  = r_idx + 1'b1;
                        n_didx = r_idx;
                        n_dv   = 1'b1;
                    end
                end else begin
                    // none of the tables: for an add, choose between the two new-table options
                    n_new   = (r_item.opcode == OP_ADD);
                    n_glob  = (r_run + TOT_W'(r_wg)) > r_target;
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                if (r_item.opcode == OP_REMOVE) begin
                    if (cnt_adj != '0) begin
                        tab_we    = 1'b1;
                        tab_wdata = {r_ent[CB], cnt_adj};
                        n_state   = S_FINISH;
                    end else begin
                        n_change = r_ent[CB] ? CHG_GLOBAL : CHG_LOCAL;
                        n_idx    = r_pick + 1'b1;
                        n_state  = S_SHIFT;
                    end
                end else if (!r_new) begin
                    tab_we    = 1'b1;
                    tab_wdata = {r_ent[CB], cnt_adj};
                    n_state   = S_FINISH;
                end else if (r_n >= N_MAX) begin
                    n_res   = '{change: CHG_NONE, status: ST_FULL};
                    n_state = S_RESULT;
                end else if (r_tot_tab == '1) begin
                    n_res   = '{change: CHG_NONE, status: ST_OVF};
                    n_state = S_RESULT;
                end else begin
                    tab_we    = 1'b1;
                    tab_waddr = {r_sec, r_n[TI_W-1:0]};
                    tab_wdata = {r_glob, CB'(1)};
                    n_change  = r_glob ? CHG_GLOBAL : CHG_LOCAL;
                    n_state   = S_FINISH;
                end
            end
            S_SHIFT: begin
                // move each later table down one slot to close the gap
                if (r_dv) begin
                    tab_we    = 1'b1;
                    tab_waddr = {r_sec, shift_dst[TI_W-1:0]};
                    tab_wdata = tab_rdata;
                end
                if (scan_issue) begin
                    n_idx  = r_idx + 1'b1;
                    n_didx = r_idx;
                    n_dv   = 1'b1;
                end else if (!r_dv) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                sec_we = 1'b1;
                if (r_item.opcode == OP_ADD) begin
                    sec_wdata  = {r_cust + 1'b1, r_n + NT_W'(r_new)};
                    n_tot_cust = r_tot_cust + 1'b1;
                    if (r_new) begin
                        n_tot_tab = r_tot_tab + 1'b1;
                    end
                end else begin
                    sec_wdata = {r_cust - 1'b1, r_n - NT_W'(r_change != CHG_NONE)};
                    if (r_tot_cust != '0) begin
                        n_tot_cust = r_tot_cust - 1'b1;
                    end
                    if (r_change != CHG_NONE && r_tot_tab != '0) begin
                        n_tot_tab = r_tot_tab - 1'b1;
                    end
                end
                n_res   = '{change: r_change, status: ST_OK};
                n_state = S_RESULT;
            end
            S_RESULT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_sec_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SECRD) |-> (32'(r_sec) < 32'(NUM_TYPES)))
        else $error("section index beyond NUM_TYPES");

    a_remove_live_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_APPLY && r_item.opcode == OP_REMOVE) |-> (r_ent[CB-1:0] != '0))
        else $error("remove picked an empty table");

    a_out_from_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_RESULT))
        else $error("result beat raised outside result state");

    a_no_accept_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> o_in_stall)
        else $error("input taken during clearing pass");

endmodule

// ----- rtl/core/crp_ram.sv -----
// Simple dual-port memory with a registered read port.
module crp_ram
    import crp_pkg::*;
#(
    parameter int DEPTH  = 1024,
    parameter int W_DATA = 8,
    parameter int W_ADDR = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [W_ADDR-1:0] i_waddr,
    input  logic [W_DATA-1:0] i_wdata,
    input  logic [W_ADDR-1:0] i_raddr,
    output logic [W_DATA-1:0] o_rdata
);

    logic [W_DATA-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
